// File: rtl/core/usb_endpoint_tx_packetizer_defines.svh
// assertion macros for the usb endpoint tx packetizer checker
// no dependencies; included by the checker file
`ifndef USB_ENDPOINT_TX_PACKETIZER_DEFINES_SVH
`define USB_ENDPOINT_TX_PACKETIZER_DEFINES_SVH

// clocked assertion with active-low reset disable
`define USBTX_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// same, bound to the usual clk and rst_n names
`define USBTX_CHECK(lbl, prop, msg) \
  `USBTX_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

// File: rtl/core/usbtx_pkg.sv
// shared constants, types and helpers for the usb endpoint tx packetizer
// no dependencies; used by the interfaces and the top level
package usbtx_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int WCNT_W    = 9;
  localparam int CMP_W     = (CNT_W > WCNT_W) ? CNT_W : WCNT_W;
  localparam int FUNC_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int PKT_W     = 7;

  localparam logic [PKT_W-1:0] PKT_MAX = 7'd64;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_OPEN     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DATA     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TX_DONE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_EP_RESET = 3'd4;

  // configuration register indexes
  localparam logic CFG_MAX_PKT = 1'b0;
  localparam logic CFG_CTRL_EP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  // clamp packet size register to 1..64
  function automatic logic [PKT_W-1:0] pkt_size(input logic [PKT_W-1:0] m);
    logic [PKT_W-1:0] r;
    if (m == '0) begin
      r = 7'd1;
    end else if (m > PKT_MAX) begin
      r = PKT_MAX;
    end else begin
      r = m;
    end
    return r;
  endfunction

  // ring index increment with wrap
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(BUF_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/usbtx_if.sv
// valid/ready channel interfaces for the usb endpoint tx packetizer
// depends on usbtx_pkg for field widths
interface usbtx_in_if;
  import usbtx_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [WCNT_W-1:0]   write_count;
  logic [BYTE_W-1:0]   data_byte;

  modport source (output valid, func, write_count, data_byte, input ready);
  modport sink   (input valid, func, write_count, data_byte, output ready);
endinterface

interface usbtx_out_if;
  import usbtx_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   fifo_byte;
  logic                byte_valid;
  logic                packet_ready;
  logic [PKT_W-1:0]    packet_length;
  logic                accepted;
  logic                last;

  modport source (output valid, fifo_byte, byte_valid, packet_ready, packet_length,
                  accepted, last, input ready);
  modport sink   (input valid, fifo_byte, byte_valid, packet_ready, packet_length,
                  accepted, last, output ready);
endinterface

// File: rtl/core/usb_endpoint_tx_packetizer.sv
// usb in endpoint transmit packetizer: ring store feeding a packet fifo
// depends on usbtx_pkg and the channel interfaces in usbtx_if.sv
// an input that moves no byte gives its single beat in the cycle after acceptance
// an input that moves bytes sends each byte through a ring memory read, then the output register
// throughput: one input per cycle without bytes while the output is not stalled; no new input during a run
// reset: counters, indexes and flags clear, max_packet_bytes 64; ring contents left as is
module usb_endpoint_tx_packetizer (
  input  logic                      clk,
  input  logic                      rst_n,
  usbtx_in_if.sink                  in_ch,
  usbtx_out_if.source               out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [usbtx_pkg::PKT_W-1:0] cfg_data
);
  import usbtx_pkg::*;

  // configuration registers
  logic [PKT_W-1:0] mpb_r;
  logic             ctrl_r;

  // endpoint state
  logic [IDX_W-1:0] put_r, put_nxt;
  logic [IDX_W-1:0] take_r;
  logic [CNT_W-1:0] queued_r, queued_nxt;
  logic [PKT_W-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [PKT_W-1:0] inflight_r, inflight_nxt;
  logic             flush_r, flush_nxt;
  logic [CNT_W-1:0] wrem_r, wrem_nxt;

  // run of byte moves for the accepted input
  state_t           state_r, state_nxt;
  logic [PKT_W-1:0] move_left_r;
  logic             commit_r;
  logic [PKT_W-1:0] commit_len_r;
  logic             acc_r;

  // ring store, one write port, one registered read port
  logic [BYTE_W-1:0] ring_mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] fifo_byte_r;
  logic              byte_valid_r;
  logic              packet_ready_r;
  logic [PKT_W-1:0]  packet_length_r;
  logic              accepted_r;
  logic              last_r;

  // handshake and control
  logic accept;
  logic out_free;
  logic in_ready_c;
  logic emit_ld;
  logic read_step;

  // per-input decode
  logic             acc_c;
  logic             do_pkt;
  logic             do_flush;
  logic             ep_reset;
  logic             mem_we_c;
  logic             commit_c;
  logic [PKT_W-1:0] pkt_sz;
  logic [PKT_W-1:0] room;
  logic [PKT_W-1:0] move_cnt;
  logic [PKT_W-1:0] fifo_fill;
  logic [CNT_W-1:0] q_base;
  logic [CNT_W-1:0] q_fill;
  logic             flush_fill;
  logic [IDX_W-1:0] put_inc;
  logic [CNT_W-1:0] span;
  logic [CMP_W-1:0] wc_ext;
  logic [CMP_W-1:0] free_ext;
  logic [CMP_W-1:0] q_ext;
  logic [CMP_W-1:0] room_ext;
  logic [CMP_W-1:0] min_ext;

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ready_c;

  assign in_ch.ready          = in_ready_c;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.fifo_byte     = fifo_byte_r;
  assign out_ch.byte_valid    = byte_valid_r;
  assign out_ch.packet_ready  = packet_ready_r;
  assign out_ch.packet_length = packet_length_r;
  assign out_ch.accepted      = accepted_r;
  assign out_ch.last          = last_r;

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && move_cnt != '0) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = (move_left_r == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_c = 1'b0;
    emit_ld    = 1'b0;
    read_step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready_c = out_free;
      end
      ST_READ: begin
        read_step = 1'b1;
      end
      ST_EMIT: begin
        emit_ld = out_free;
      end
      default: begin
        in_ready_c = 1'b0;
      end
    endcase
  end

  // endpoint update for the input at the channel head
  always_comb begin
    pkt_sz   = pkt_size(mpb_r);
    put_inc  = idx_inc(put_r);
    wc_ext   = CMP_W'(in_ch.write_count);
    free_ext = CMP_W'(BUF_DEPTH) - CMP_W'(queued_r);

    // bytes between take and the new put, a full ring counts as the whole depth
    if (put_inc > take_r) begin
      span = CNT_W'(put_inc) - CNT_W'(take_r);
    end else if (put_inc == take_r) begin
      span = CNT_W'(BUF_DEPTH);
    end else begin
      span = CNT_W'(put_inc) + CNT_W'(BUF_DEPTH) - CNT_W'(take_r);
    end

    put_nxt  = put_r;
    wrem_nxt = wrem_r;
    q_base   = queued_r;
    acc_c    = 1'b1;
    do_pkt   = 1'b0;
    do_flush = 1'b0;
    ep_reset = 1'b0;
    mem_we_c = 1'b0;

    case (in_ch.func)
      FUNC_OPEN: begin
        if (wrem_r != '0 || wc_ext > free_ext) begin
          acc_c = 1'b0;
        end else if (wc_ext == '0) begin
          do_pkt = (inflight_r == '0);
        end else begin
          wrem_nxt = wc_ext[CNT_W-1:0];
        end
      end
      FUNC_DATA: begin
        if (wrem_r == '0) begin
          acc_c = 1'b0;
        end else begin
          mem_we_c = 1'b1;
          put_nxt  = put_inc;
          wrem_nxt = wrem_r - CNT_W'(1);
          // write completes: its bytes become visible
          if (wrem_r == CNT_W'(1)) begin
            q_base = span;
            do_pkt = (inflight_r == '0);
          end
        end
      end
      FUNC_TX_DONE: begin
        do_pkt = 1'b1;
      end
      FUNC_FLUSH: begin
        do_flush = 1'b1;
      end
      FUNC_EP_RESET: begin
        ep_reset = 1'b1;
      end
      default: begin
        acc_c = 1'b0;
      end
    endcase

    // fifo fill: shrunk packet size leaves no room
    room     = (pkt_sz > fifo_cnt_r) ? (pkt_sz - fifo_cnt_r) : '0;
    q_ext    = CMP_W'(q_base);
    room_ext = CMP_W'(room);
    min_ext  = (q_ext < room_ext) ? q_ext : room_ext;
    move_cnt = (do_pkt || do_flush) ? min_ext[PKT_W-1:0] : '0;

    fifo_fill  = fifo_cnt_r + move_cnt;
    q_fill     = q_base - CNT_W'(move_cnt);
    flush_fill = flush_r || do_flush || (do_pkt && q_fill == '0 && ctrl_r);

    if (do_pkt) begin
      commit_c = (fifo_fill >= pkt_sz) || flush_fill;
    end else begin
      commit_c = do_flush && (inflight_r == '0);
    end

    queued_nxt   = q_fill;
    fifo_cnt_nxt = fifo_fill;
    flush_nxt    = flush_fill;
    inflight_nxt = do_pkt ? '0 : inflight_r;

    // commit: fifo contents go in flight, a short packet ends the flush
    if (commit_c) begin
      inflight_nxt = fifo_fill;
      fifo_cnt_nxt = '0;
      if (fifo_fill < pkt_sz) begin
        flush_nxt = 1'b0;
      end
    end

    if (ep_reset) begin
      put_nxt      = '0;
      wrem_nxt     = '0;
      queued_nxt   = '0;
      fifo_cnt_nxt = '0;
      inflight_nxt = '0;
      flush_nxt    = 1'b0;
    end
  end

  // ring memory: writes only at accept, reads only in a later read state
  always_ff @(posedge clk) begin
    if (accept && mem_we_c) begin
      ring_mem[put_r] <= in_ch.data_byte;
    end
    // read data holds while the result beat waits
    if (read_step) begin
      rd_data_r <= ring_mem[take_r];
    end
  end

  // config, endpoint state and run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpb_r       <= PKT_MAX;
      ctrl_r      <= 1'b0;
      put_r       <= '0;
      take_r      <= '0;
      queued_r    <= '0;
      fifo_cnt_r  <= '0;
      inflight_r  <= '0;
      flush_r     <= 1'b0;
      wrem_r      <= '0;
      state_r     <= ST_IDLE;
      move_left_r <= '0;
      commit_r    <= 1'b0;
      acc_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_PKT: mpb_r  <= cfg_data;
          CFG_CTRL_EP: ctrl_r <= cfg_data[0];
          default:     mpb_r  <= mpb_r;
        endcase
      end
      if (accept) begin
        put_r       <= put_nxt;
        queued_r    <= queued_nxt;
        fifo_cnt_r  <= fifo_cnt_nxt;
        inflight_r  <= inflight_nxt;
        flush_r     <= flush_nxt;
        wrem_r      <= wrem_nxt;
        move_left_r <= move_cnt;
        commit_r    <= commit_c;
        acc_r       <= acc_c;
        if (ep_reset) begin
          take_r <= '0;
        end
      end else if (read_step) begin
        take_r      <= idx_inc(take_r);
        move_left_r <= move_left_r - PKT_W'(1);
      end
    end
  end

  // commit length travels with the run, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      commit_len_r <= inflight_nxt;
    end
  end

  // output register: empty result straight from accept, bytes from the ring read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && move_cnt == '0) begin
      out_valid_r <= 1'b1;
    end else if (emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && move_cnt == '0) begin
      fifo_byte_r     <= '0;
      byte_valid_r    <= 1'b0;
      packet_ready_r  <= commit_c;
      packet_length_r <= commit_c ? inflight_nxt : '0;
      accepted_r      <= acc_c;
      last_r          <= 1'b1;
    end else if (emit_ld) begin
      fifo_byte_r     <= rd_data_r;
      byte_valid_r    <= 1'b1;
      packet_ready_r  <= commit_r && (move_left_r == '0);
      packet_length_r <= (commit_r && move_left_r == '0) ? commit_len_r : '0;
      accepted_r      <= acc_r;
      last_r          <= (move_left_r == '0);
    end
  end

endmodule

// File: rtl/core/usbtx_checker.sv
// port-level checks for usb_endpoint_tx_packetizer, attached by bind
// depends on usb_endpoint_tx_packetizer_defines.svh
`include "usb_endpoint_tx_packetizer_defines.svh"

module usbtx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] fifo_byte,
  input logic       byte_valid,
  input logic       packet_ready,
  input logic [6:0] packet_length,
  input logic       last
);

  // stalled beat keeps its payload
  `USBTX_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(fifo_byte) && $stable(packet_length) && $stable(last), "result beat changed while stalled")

  // an empty result only closes a run
  `USBTX_CHECK(a_empty_last, out_valid && !byte_valid |-> last && fifo_byte == 8'd0, "empty result before end of run")

  // commit only on the final beat, within the packet size
  `USBTX_CHECK(a_commit_last, out_valid && packet_ready |-> last && packet_length <= 7'd64, "commit not on final beat")

  `USBTX_ASSERT(a_len_zero, clk, rst_n, out_valid && !packet_ready |-> packet_length == 7'd0, "length without commit")

  // no new input while a run still has bytes to send
  `USBTX_CHECK(a_run_busy, out_valid && !last |-> !in_ready, "input taken mid-run")

endmodule

bind usb_endpoint_tx_packetizer usbtx_checker u_usbtx_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .fifo_byte     (out_ch.fifo_byte),
  .byte_valid    (out_ch.byte_valid),
  .packet_ready  (out_ch.packet_ready),
  .packet_length (out_ch.packet_length),
  .last          (out_ch.last)
);
